[sv/sbss_pkg.sv]
// ----------------------------------------------------------------------------
// sbss_pkg
// Shared types and constants for the stereo bus splitter with sidechain.
// ----------------------------------------------------------------------------
package sbss_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;
  localparam int NUM_REGS        = 6;
  localparam int IDX_W           = 3;

  // Smoother coefficient 0.002 in Q0.32, select threshold 0.001 in Q1.31
  localparam logic [31:0] SMOOTH_K   = 32'd8589935;
  localparam logic [31:0] SEL_THRESH = 32'd2147484;
  localparam logic [31:0] Q31_ONE    = 32'h8000_0000;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_FADE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_AUX    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MODE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SELECT = 3'd4;
  localparam logic [IDX_W-1:0] REG_KEY    = 3'd5;

  typedef enum logic [1:0] {
    SH_30,
    SH_31,
    SH_32
  } shift_e;

  // One datapath step per cycle through the shared multiplier
  typedef enum logic [4:0] {
    ST_SM_MAIN,
    ST_SM_AUX,
    ST_SM_MODE,
    ST_SM_SEL,
    ST_SM_KEY,
    ST_MAIN_A,
    ST_MIX_B,
    ST_MAIN_B,
    ST_MIX_A,
    ST_AUX_A,
    ST_AUX_B,
    ST_OUT0,
    ST_OUT1,
    ST_OUT2,
    ST_OUT3,
    ST_KEY_L,
    ST_KEY_R,
    ST_TGT_D,
    ST_TGT_L,
    ST_TGT_R,
    ST_OUT4
  } step_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  load;
    logic  run;
    step_e step;
    logic  publish;
  } sbss_cmd_t;

endpackage

[sv/sbss_ctrl.sv]
// ----------------------------------------------------------------------------
// sbss_ctrl
// Frame sequencer: accepts a word, walks the datapath steps, hands off result.
// ----------------------------------------------------------------------------
module sbss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sbss_pkg::sbss_cmd_t cmd_o
);
  import sbss_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o        = '0;
    cmd_o.step   = step_e'(step_q);
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        step_d    = step_q + 5'd1;
        if (step_e'(step_q) == ST_OUT4) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_vld_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.publish) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

[sv/sbss_dp.sv]
// ----------------------------------------------------------------------------
// sbss_dp
// Datapath: config bank, smoothers, shared rounding multiplier, output word.
// ----------------------------------------------------------------------------
module sbss_dp #(
  parameter int SAMPLE_BITS = sbss_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sbss_pkg::COEF_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sbss_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_BITS-1:0]       cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]     left_i,
  input  logic [SAMPLE_BITS-1:0]     right_i,
  input  logic [SAMPLE_BITS-1:0]     det_i,
  input  sbss_pkg::sbss_cmd_t        cmd_i,
  output logic [SAMPLE_BITS-1:0]     main_left_o,
  output logic [SAMPLE_BITS-1:0]     main_right_o,
  output logic [SAMPLE_BITS-1:0]     aux_left_o,
  output logic [SAMPLE_BITS-1:0]     aux_right_o,
  output logic [SAMPLE_BITS-1:0]     det_o
);
  import sbss_pkg::*;

  localparam int XW = (SAMPLE_BITS + 3 > 33) ? SAMPLE_BITS + 3 : 33;
  localparam int PW = XW + 33;
  localparam logic [COEF_BITS-1:0] REG_ONE = COEF_BITS'(1) << (COEF_BITS - 1);
  localparam logic signed [XW-1:0] LIMIT = XW'(1) <<< (SAMPLE_BITS - 1);
  localparam logic signed [XW-1:0] FULL  = XW'(1) <<< (SAMPLE_BITS - 4);

  function automatic logic signed [XW-1:0] guard(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = v;
    if (v >= LIMIT || v <= -LIMIT) r = '0;
    return r;
  endfunction

  function automatic logic signed [XW-1:0] clipfs(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = v;
    if (v > FULL) r = FULL;
    else if (v < -FULL) r = -FULL;
    return r;
  endfunction

  function automatic logic [31:0] q31(input logic [COEF_BITS-1:0] r);
    logic [COEF_BITS-1:0] s;
    s = (r > REG_ONE) ? REG_ONE : r;
    return 32'(s) << (32 - COEF_BITS);
  endfunction

  function automatic logic signed [XW-1:0] ext32(input logic [31:0] v);
    return $signed({{(XW-32){1'b0}}, v});
  endfunction

  logic [COEF_BITS-1:0] cfg_q [NUM_REGS];
  logic [31:0] sm_q, sx_q, sd_q, sc_q, sk_q;
  logic        snapped_q, side_q;
  logic signed [XW-1:0] a_q, b_q, dry_q, ma_q, mb_q, aa_q, ab_q, pre_q;
  logic signed [XW-1:0] kl_q, kr_q, acc_q;
  logic signed [XW-1:0] r0_q, r1_q, r2_q, r3_q, r4_q;
  logic [SAMPLE_BITS-1:0] o0_q, o1_q, o2_q, o3_q, o4_q;

  logic [31:0] fade, mt, xt, dt, ct, lt, sel_now;
  logic [32:0] x2, d1;
  logic [31:0] w_off, w_l, w_r;

  assign fade = q31(cfg_q[REG_FADE]);
  assign mt   = q31(cfg_q[REG_MAIN]);
  assign xt   = q31(cfg_q[REG_AUX]);
  assign dt   = q31(cfg_q[REG_MODE]);
  assign ct   = q31(cfg_q[REG_SELECT]);
  assign lt   = q31(cfg_q[REG_KEY]);
  assign sel_now = snapped_q ? sc_q : ct;

  // triangular weights over the smoothed selector
  always_comb begin
    x2    = {sc_q, 1'b0};
    d1    = (x2 >= 33'(Q31_ONE)) ? x2 - 33'(Q31_ONE) : 33'(Q31_ONE) - x2;
    w_off = (x2 >= 33'(Q31_ONE)) ? 32'd0 : 32'(33'(Q31_ONE) - x2);
    w_l   = 32'(33'(Q31_ONE) - d1);
    w_r   = (x2 > 33'(Q31_ONE)) ? 32'(x2 - 33'(Q31_ONE)) : 32'd0;
  end

  // shared multiplier: round(x * q / 2^sh), halves away from zero
  logic signed [XW-1:0] mx, mres;
  logic [31:0]          mq;
  shift_e               msh;
  logic [XW-1:0]        mag;
  logic [PW-1:0]        prod, rnd;
  logic [XW-1:0]        rmag;
  logic [31:0]          s_cur, t_cur;

  always_comb begin
    s_cur = sm_q;
    t_cur = mt;
    case (cmd_i.step)
      ST_SM_AUX:  begin s_cur = sx_q; t_cur = xt; end
      ST_SM_MODE: begin s_cur = sd_q; t_cur = dt; end
      ST_SM_SEL:  begin s_cur = sc_q; t_cur = ct; end
      ST_SM_KEY:  begin s_cur = sk_q; t_cur = lt; end
      default:    begin s_cur = sm_q; t_cur = mt; end
    endcase
    mx  = a_q;
    mq  = fade;
    msh = SH_31;
    unique case (cmd_i.step)
      ST_SM_MAIN, ST_SM_AUX, ST_SM_MODE, ST_SM_SEL, ST_SM_KEY: begin
        mx  = ext32(t_cur) - ext32(s_cur);
        mq  = SMOOTH_K;
        msh = SH_32;
      end
      ST_MAIN_A: begin mx = a_q;          mq = sm_q;  end
      ST_MIX_B:  begin mx = b_q - a_q;    mq = sd_q;  end
      ST_MAIN_B: begin mx = pre_q;        mq = sm_q;  end
      ST_MIX_A:  begin mx = a_q - b_q;    mq = sd_q;  end
      ST_AUX_A:  begin mx = pre_q;        mq = sx_q;  end
      ST_AUX_B:  begin mx = b_q;          mq = sx_q;  end
      ST_OUT0:   begin mx = ma_q - a_q;   mq = fade;  end
      ST_OUT1:   begin mx = mb_q - b_q;   mq = fade;  end
      ST_OUT2:   begin mx = aa_q;         mq = fade;  end
      ST_OUT3:   begin mx = ab_q;         mq = fade;  end
      ST_KEY_L:  begin mx = a_q;          mq = sk_q; msh = SH_30; end
      ST_KEY_R:  begin mx = b_q;          mq = sk_q; msh = SH_30; end
      ST_TGT_D:  begin mx = dry_q;        mq = w_off; end
      ST_TGT_L:  begin mx = kl_q;         mq = w_l;   end
      ST_TGT_R:  begin mx = kr_q;         mq = w_r;   end
      ST_OUT4:   begin mx = acc_q - dry_q; mq = fade; end
      default:   begin mx = a_q;          mq = fade;  end
    endcase
    mag  = mx[XW-1] ? $unsigned(-mx) : $unsigned(mx);
    prod = PW'(mag) * PW'(mq);
    unique case (msh)
      SH_30:   begin rnd = prod + (PW'(1) << 29); rmag = XW'(rnd >> 30); end
      SH_31:   begin rnd = prod + (PW'(1) << 30); rmag = XW'(rnd >> 31); end
      SH_32:   begin rnd = prod + (PW'(1) << 31); rmag = XW'(rnd >> 32); end
      default: begin rnd = prod;                  rmag = XW'(rnd >> 31); end
    endcase
    mres = mx[XW-1] ? -$signed(rmag) : $signed(rmag);
  end

  logic [31:0] s_new;
  assign s_new = 32'(ext32(s_cur) + mres);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_FADE]   <= REG_ONE;
      cfg_q[REG_MAIN]   <= REG_ONE;
      cfg_q[REG_AUX]    <= REG_ONE;
      cfg_q[REG_MODE]   <= '0;
      cfg_q[REG_SELECT] <= '0;
      cfg_q[REG_KEY]    <= REG_ONE >> 1;
      sm_q      <= '0;
      sx_q      <= '0;
      sd_q      <= '0;
      sc_q      <= '0;
      sk_q      <= '0;
      snapped_q <= 1'b0;
      side_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < IDX_W'(NUM_REGS))) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
      if (cmd_i.load) begin
        // first frame loads every smoother with its target
        if (!snapped_q) begin
          sm_q <= mt;
          sx_q <= xt;
          sd_q <= dt;
          sc_q <= ct;
          sk_q <= lt;
        end
        snapped_q <= 1'b1;
        side_q    <= (fade != '0) && ((ct > SEL_THRESH) || (sel_now > SEL_THRESH));
      end
      if (cmd_i.run) begin
        case (cmd_i.step)
          ST_SM_MAIN: sm_q <= s_new;
          ST_SM_AUX:  sx_q <= s_new;
          ST_SM_MODE: sd_q <= s_new;
          ST_SM_SEL:  sc_q <= s_new;
          ST_SM_KEY:  sk_q <= s_new;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= {{(XW-SAMPLE_BITS){left_i[SAMPLE_BITS-1]}}, left_i};
      b_q   <= {{(XW-SAMPLE_BITS){right_i[SAMPLE_BITS-1]}}, right_i};
      dry_q <= {{(XW-SAMPLE_BITS){det_i[SAMPLE_BITS-1]}}, det_i};
    end
    if (cmd_i.run) begin
      case (cmd_i.step)
        ST_MAIN_A: ma_q  <= mres;
        ST_MIX_B:  pre_q <= a_q + mres;
        ST_MAIN_B: mb_q  <= mres;
        ST_MIX_A:  pre_q <= b_q + mres;
        ST_AUX_A:  aa_q  <= mres;
        ST_AUX_B:  ab_q  <= mres;
        ST_OUT0:   r0_q  <= guard(a_q + mres);
        ST_OUT1:   r1_q  <= guard(b_q + mres);
        ST_OUT2:   r2_q  <= guard(mres);
        ST_OUT3:   r3_q  <= guard(mres);
        ST_KEY_L:  kl_q  <= clipfs(mres);
        ST_KEY_R:  kr_q  <= clipfs(mres);
        ST_TGT_D:  acc_q <= mres;
        ST_TGT_L:  acc_q <= acc_q + mres;
        ST_TGT_R:  acc_q <= acc_q + mres;
        ST_OUT4:   r4_q  <= side_q ? guard(dry_q + mres) : dry_q;
        default:   ;
      endcase
    end
    if (cmd_i.publish) begin
      o0_q <= r0_q[SAMPLE_BITS-1:0];
      o1_q <= r1_q[SAMPLE_BITS-1:0];
      o2_q <= r2_q[SAMPLE_BITS-1:0];
      o3_q <= r3_q[SAMPLE_BITS-1:0];
      o4_q <= r4_q[SAMPLE_BITS-1:0];
    end
  end

  assign main_left_o  = o0_q;
  assign main_right_o = o1_q;
  assign aux_left_o   = o2_q;
  assign aux_right_o  = o3_q;
  assign det_o        = o4_q;

endmodule

[sv/stereo_bus_splitter_sidechain.sv]
// ----------------------------------------------------------------------------
// stereo_bus_splitter_sidechain
// Splits a stereo frame onto main and aux buses and rewrites a detector feed.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per frame: left, right and the dry
//   detector sample. The master channel returns one word per frame: main
//   left/right, aux left/right and the detector output.
//   The config port writes one gain/mode register per cycle when cfg_we_i is
//   high; write only while no frame is in flight.
// Sequencing:
//   An accepted frame walks 21 steps through the single shared rounding
//   multiplier, one per cycle, then waits to be handed off into the output
//   register until it is free; a new word is taken only after that handoff.
// Reset:
//   Registers return to their defaults and smoothers clear; the first frame
//   after reset loads every smoother with its target.
// Stall:
//   The result word sits in the output register while m_axis_tready is low;
//   the next frame is accepted and computed meanwhile, and it waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module stereo_bus_splitter_sidechain #(
  parameter int SAMPLE_BITS = sbss_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sbss_pkg::COEF_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sbss_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_BITS-1:0]       cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // left_in, right_in, detector_in (lowest first), zero padded to bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // main_left, main_right, aux_left, aux_right, detector_out (lowest first)
  output logic [((5*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);
  import sbss_pkg::*;

  localparam int OUT_W = ((5*SAMPLE_BITS+7)/8)*8;

  sbss_cmd_t cmd;
  logic [SAMPLE_BITS-1:0] ml, mr, al, ar, dt;

  sbss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sbss_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .left_i       (s_axis_tdata[SAMPLE_BITS-1:0]),
    .right_i      (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .det_i        (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .cmd_i        (cmd),
    .main_left_o  (ml),
    .main_right_o (mr),
    .aux_left_o   (al),
    .aux_right_o  (ar),
    .det_o        (dt)
  );

  // pack the result word, padding bits held at zero
  assign m_axis_tdata = OUT_W'({dt, ar, al, mr, ml});

endmodule

[sv/sbss_checker.sv]
// ----------------------------------------------------------------------------
// sbss_checker
// Port-level checks for the splitter, bound to the top level.
// ----------------------------------------------------------------------------
module sbss_checker #(
  parameter int OUT_W = 120
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one frame in flight: no second word right after an accept
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // a result never appears the cycle after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind stereo_bus_splitter_sidechain sbss_checker #(
  .OUT_W (((5*SAMPLE_BITS+7)/8)*8)
) u_sbss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
